### rtl/core/zxz_pkg.sv
// Shared types, constants and the arctangent table of the ZXZ rotation-matrix block.
package zxz_pkg;

	localparam int CordicSteps = 30;
	localparam int DataW       = 34;
	localparam logic signed [DataW-1:0] CordicX0 = 34'sd652032874;
	localparam logic signed [DataW-1:0] OneQ30   = 34'sd1073741824;

	typedef logic signed [DataW-1:0] q30_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	function automatic q30_t atan_turn(input int i);
		q30_t r;
		unique case (i)
			0: r = 34'sd536870912;
			1: r = 34'sd316933406;
			2: r = 34'sd167458907;
			3: r = 34'sd85004756;
			4: r = 34'sd42667331;
			5: r = 34'sd21354465;
			6: r = 34'sd10679838;
			7: r = 34'sd5340245;
			8: r = 34'sd2670163;
			9: r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			24: r = 34'sd41;
			25: r = 34'sd20;
			26: r = 34'sd10;
			27: r = 34'sd5;
			28: r = 34'sd3;
			29: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic q30_t clamp_q30(input q30_t v);
		q30_t r;
		if (v > OneQ30)
			r = OneQ30;
		else if (v < -OneQ30)
			r = -OneQ30;
		else
			r = v;
		return r;
	endfunction

endpackage

### rtl/core/zxz_euler_rotation_matrix_top.sv
// Top level of the ZXZ Euler-angle rotation-matrix pipeline.
//  channel | dir | fields
//  s_axis  | in  | tdata: angle_psi, angle_theta, angle_phi
//  m_axis  | out | tdata: m_r0_c0 .. m_r2_c2, row-major
// One item per cycle while the output is not stalled; stages: 31 CORDIC, 1 fold, 2 multiply, 1 add, 1 output.
// The whole pipeline advances when the output register is empty or being drained.
// Reset clears the valid bits only; a stall holds every stage.
module zxz_euler_rotation_matrix_top import zxz_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// psi, theta, phi from bit 0 up
	input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 from bit 0 up
	output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);

	localparam int OutW = FRAC_BITS + 2;
	localparam int Lat  = CordicSteps + 5;
	localparam int Sh   = 30 - FRAC_BITS;
	localparam int TdW  = ((9*OutW+7)/8)*8;
	localparam q30_t Lim = q30_t'(1) <<< FRAC_BITS;
	localparam q30_t Half = (Sh > 0) ? (q30_t'(1) <<< (Sh > 0 ? Sh-1 : 0)) : q30_t'(0);

	logic          en;
	logic [Lat-1:0] vld_q;
	q30_t spsi, cpsi, sth, cth, sphi, cphi;
	q30_t st, ct, cth_s2, sphi_s2, cphi_s2;
	q30_t p_cc, p_ss, p_cs, p_sc, p_ssth, p_csth, p_ths, p_thc;
	q30_t p_st_s, p_st_c, p_ct_s, p_ct_c, cth_s3;
	q30_t e_s5 [9];
	logic [OutW-1:0] o_q [9];
	logic [TdW-1:0]  tdata_c;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
			m_axis_tvalid <= vld_q[Lat-1];
		end
	end

	zxz_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_psi (.clk, .en,
		.angle(s_axis_tdata[ANGLE_BITS-1:0]), .sin_q(spsi), .cos_q(cpsi));
	zxz_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_th (.clk, .en,
		.angle(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]), .sin_q(sth), .cos_q(cth));
	zxz_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_phi (.clk, .en,
		.angle(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]), .sin_q(sphi), .cos_q(cphi));

	// first product rank
	zxz_mul u_st (.clk, .en, .a(spsi), .b(cth), .p_q(st));
	zxz_mul u_ct (.clk, .en, .a(cpsi), .b(cth), .p_q(ct));
	zxz_mul u_cc (.clk, .en, .a(cpsi), .b(cphi), .p_q(p_cc));
	zxz_mul u_ss (.clk, .en, .a(spsi), .b(sphi), .p_q(p_ss));
	zxz_mul u_cs (.clk, .en, .a(cpsi), .b(sphi), .p_q(p_cs));
	zxz_mul u_sc (.clk, .en, .a(spsi), .b(cphi), .p_q(p_sc));
	zxz_mul u_sst (.clk, .en, .a(spsi), .b(sth), .p_q(p_ssth));
	zxz_mul u_cst (.clk, .en, .a(cpsi), .b(sth), .p_q(p_csth));
	zxz_mul u_ths (.clk, .en, .a(sth), .b(sphi), .p_q(p_ths));
	zxz_mul u_thc (.clk, .en, .a(sth), .b(cphi), .p_q(p_thc));

	always_ff @(posedge clk) begin
		if (en) begin
			sphi_s2 <= sphi; cphi_s2 <= cphi; cth_s2 <= cth;
			cth_s3 <= cth_s2;
		end
	end

	// second product rank uses the rounded partial products
	zxz_mul u_sts (.clk, .en, .a(st), .b(sphi_s2), .p_q(p_st_s));
	zxz_mul u_stc (.clk, .en, .a(st), .b(cphi_s2), .p_q(p_st_c));
	zxz_mul u_cts (.clk, .en, .a(ct), .b(sphi_s2), .p_q(p_ct_s));
	zxz_mul u_ctc (.clk, .en, .a(ct), .b(cphi_s2), .p_q(p_ct_c));

	q30_t cc_s3, ss_s3, cs_s3, sc_s3, ssth_s3, csth_s3, ths_s3, thc_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			cc_s3 <= p_cc; ss_s3 <= p_ss; cs_s3 <= p_cs; sc_s3 <= p_sc;
			ssth_s3 <= p_ssth; csth_s3 <= p_csth; ths_s3 <= p_ths; thc_s3 <= p_thc;
			e_s5[0] <= cc_s3 - p_st_s;
			e_s5[1] <= -cs_s3 - p_st_c;
			e_s5[2] <= ssth_s3;
			e_s5[3] <= sc_s3 + p_ct_s;
			e_s5[4] <= -ss_s3 + p_ct_c;
			e_s5[5] <= -csth_s3;
			e_s5[6] <= ths_s3;
			e_s5[7] <= thc_s3;
			e_s5[8] <= cth_s3;
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_out
		q30_t r;
		assign r = (e_s5[k] + Half) >>> Sh;
		always_ff @(posedge clk) begin
			if (en) begin
				if (r > Lim)
					o_q[k] <= OutW'(Lim);
				else if (r < -Lim)
					o_q[k] <= OutW'(-Lim);
				else
					o_q[k] <= OutW'(r);
			end
		end
		assign tdata_c[k*OutW +: OutW] = o_q[k];
	end
	if (TdW > 9*OutW) begin : g_pad
		assign tdata_c[TdW-1:9*OutW] = '0;
	end

	assign m_axis_tdata = tdata_c;

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !vld_q[Lat-1]) |=> !m_axis_tvalid)
		else $error("output valid without a request in the last stage");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during a stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow the output stage");

endmodule

### rtl/core/zxz_cordic.sv
// Pipelined rotation-mode CORDIC: one micro-rotation per stage, then quadrant folding.
module zxz_cordic import zxz_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] angle,
	output q30_t                  sin_q,
	output q30_t                  cos_q
);

	logic [31:0] a32;
	q30_t        x_s1 [CordicSteps+1];
	q30_t        y_s1 [CordicSteps+1];
	q30_t        z_s1 [CordicSteps+1];
	quad_t       quad_s1 [CordicSteps+1];
	q30_t        c_cl, s_cl;

	assign a32 = 32'(angle) << (32 - ANGLE_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1[0]    <= CordicX0;
			y_s1[0]    <= '0;
			z_s1[0]    <= q30_t'({4'd0, a32[29:0]});
			quad_s1[0] <= quad_t'(a32[31:30]);
		end
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s1[i][DataW-1]) begin
					x_s1[i+1] <= x_s1[i] - (y_s1[i] >>> i);
					y_s1[i+1] <= y_s1[i] + (x_s1[i] >>> i);
					z_s1[i+1] <= z_s1[i] - atan_turn(i);
				end else begin
					x_s1[i+1] <= x_s1[i] + (y_s1[i] >>> i);
					y_s1[i+1] <= y_s1[i] - (x_s1[i] >>> i);
					z_s1[i+1] <= z_s1[i] + atan_turn(i);
				end
				quad_s1[i+1] <= quad_s1[i];
			end
		end
	end

	assign c_cl = clamp_q30(x_s1[CordicSteps]);
	assign s_cl = clamp_q30(y_s1[CordicSteps]);

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_s1[CordicSteps])
				QUAD_0: begin cos_q <= c_cl;  sin_q <= s_cl;  end
				QUAD_1: begin cos_q <= -s_cl; sin_q <= c_cl;  end
				QUAD_2: begin cos_q <= -c_cl; sin_q <= -s_cl; end
				QUAD_3: begin cos_q <= s_cl;  sin_q <= -c_cl; end
				default: begin cos_q <= c_cl; sin_q <= s_cl; end
			endcase
		end
	end

endmodule

### rtl/core/zxz_mul.sv
// Registered signed 34-bit Q3.30 product rounded to nearest.
module zxz_mul import zxz_pkg::*; (
	input  logic clk,
	input  logic en,
	input  q30_t a,
	input  q30_t b,
	output q30_t p_q
);

	logic signed [2*DataW-1:0] prod;

	assign prod = (a * b) + (68'sd1 <<< 29);

	always_ff @(posedge clk) begin
		if (en)
			p_q <= q30_t'(prod >>> 30);
	end

endmodule
